[src/hed_pkg.sv]
// shared types, constants and helpers for the html entity decoder
// no dependencies; imported by every module of the block
package hed_pkg;

   localparam int HOLD_DEPTH  = 5;
   localparam int BURST_MAX   = 6;
   localparam int ENT_COUNT   = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] AMP_CHAR = 8'h26;

   // entity spellings, lower case, unused tail bytes zero
   localparam logic [7:0] ENT_TEXT [ENT_COUNT][BURST_MAX] = '{
      '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // &amp;
      '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // &quot;
      '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},   // &apos;
      '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // &lt;
      '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}    // &gt;
   };
   localparam logic [2:0] ENT_LEN  [ENT_COUNT] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd4};
   localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{8'h26, 8'h22, 8'h27, 8'h3c, 8'h3e};

   // group of result bytes caused by one input item
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      is_final;
   } burst_type;

   // ascii upper case folds to lower case, all else unchanged
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a) begin
         return c + 8'd32;
      end
      return c;
   endfunction

endpackage

[src/hed_chan_if.sv]
// valid/ready channels of the html entity decoder: text input and results
// no dependencies
interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_final;

   modport source (output valid, output in_byte, output in_final, input ready);
   modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output run_last, output text_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input text_end,
                   output ready);
endinterface

[src/hed_front.sv]
// front end: accepts text bytes, tracks the pending partial match and
// forms the burst of result bytes for each item; uses hed_pkg, hed_req_if
module hed_front (
   input  logic              clock,
   input  logic              reset,
   hed_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push,
   output hed_pkg::burst_type push_burst
);
   import hed_pkg::*;

   logic [7:0] held_ff [HOLD_DEPTH];
   logic [7:0] held_in [HOLD_DEPTH];
   logic [2:0] count_ff, count_in;

   logic       fire;
   logic       match_full, match_part;
   logic [7:0] ent_sel;
   logic [7:0] b;
   logic [2:0] n;
   burst_type  burst;

   assign req_chan.ready = !queue_full;
   assign fire = req_chan.valid && req_chan.ready;
   assign b    = req_chan.in_byte;
   assign n    = count_ff;

   // parallel compare of held bytes plus new byte against every entity
   always_comb begin
      logic pre_ok;
      match_full = 1'b0;
      match_part = 1'b0;
      ent_sel    = ENT_CHAR[0];
      for (int e = 0; e < ENT_COUNT; e++) begin
         pre_ok = ({1'b0, n} + 4'd1) <= {1'b0, ENT_LEN[e]};
         for (int i = 0; i < BURST_MAX; i++) begin
            if (3'(i) < n) begin
               if (i < HOLD_DEPTH) begin
                  pre_ok = pre_ok && (fold_case(held_ff[i]) == ENT_TEXT[e][i]);
               end
            end else if (3'(i) == n) begin
               pre_ok = pre_ok && (fold_case(b) == ENT_TEXT[e][i]);
            end
         end
         if (pre_ok && (n != 3'd0)) begin
            if (({1'b0, n} + 4'd1) == {1'b0, ENT_LEN[e]}) begin
               match_full = 1'b1;
               ent_sel    = ENT_CHAR[e];
            end else begin
               match_part = 1'b1;
            end
         end
      end
   end

   // burst is held bytes and new byte, held bytes alone, or a decoded char
   always_comb begin
      held_in        = held_ff;
      count_in       = count_ff;
      burst.is_final = req_chan.in_final;
      for (int i = 0; i < BURST_MAX; i++) begin
         burst.bytes[i] = b;
      end
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (3'(i) < n) begin
            burst.bytes[i] = held_ff[i];
         end
      end
      burst.count = 3'd0;
      priority if (match_full) begin
         burst.bytes[0] = ent_sel;
         burst.count    = 3'd1;
         count_in       = 3'd0;
      end else if (req_chan.in_final) begin
         burst.count = n + 3'd1;
         count_in    = 3'd0;
      end else if (n == 3'd0) begin
         if (b == AMP_CHAR) begin
            held_in[0] = b;
            count_in   = 3'd1;
         end else begin
            burst.count = 3'd1;
         end
      end else if (match_part && (n < 3'(HOLD_DEPTH))) begin
         held_in[n] = b;
         count_in   = n + 3'd1;
      end else begin
         if (b == AMP_CHAR) begin
            burst.count = n;
            held_in[0]  = b;
            count_in    = 3'd1;
         end else begin
            burst.count = n + 3'd1;
            count_in    = 3'd0;
         end
      end
   end

   assign push       = fire && (burst.count != 3'd0);
   assign push_burst = burst;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

[src/hed_queue.sv]
// two-entry burst queue between front and back end
// uses hed_pkg
module hed_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hed_pkg::burst_type push_burst,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output hed_pkg::burst_type pop_burst
);
   import hed_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   burst_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;

   assign full      = fill_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_burst = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_burst;
      end
   end

endmodule

[src/hed_back.sv]
// back end: plays out one queued burst as a run of result items
// uses hed_pkg, hed_rsp_if
module hed_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  hed_pkg::burst_type pop_burst,
   output logic              pop,
   hed_rsp_if.source         rsp_chan
);
   import hed_pkg::*;

   burst_type  burst_ff;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       fire, last;

   assign last = idx_ff == (burst_ff.count - 3'd1);
   assign fire = rsp_chan.valid && rsp_chan.ready;
   assign pop  = not_empty && (!busy_ff || (fire && last));

   assign rsp_chan.valid    = busy_ff;
   assign rsp_chan.out_byte = burst_ff.bytes[idx_ff];
   assign rsp_chan.run_last = last;
   assign rsp_chan.text_end = last && burst_ff.is_final;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         burst_ff <= pop_burst;
      end
   end

endmodule

[src/html_entity_decoder_unit.sv]
// top level of the html entity decoder
// uses hed_pkg, hed_req_if, hed_rsp_if, hed_front, hed_queue, hed_back
//
// Decodes &amp; &quot; &apos; &lt; &gt; (any ascii letter case) in a byte
// stream into & " ' < >; everything else passes through unchanged. The
// input takes one byte per cycle whenever the two-entry burst queue has
// room. Each input byte causes zero to six result items; the back end
// sends one result per cycle while the output is ready, so a byte that
// breaks a long partial match (up to five held bytes plus itself) keeps
// the output busy for up to six results, and input stalls only once two
// bursts are queued behind the one playing out. Each burst is registered
// first in the queue and then in the back end before its first result
// shows. run_last marks the last result of each input byte, text_end the
// last result of a final byte. No clearing pass is needed after reset.
module html_entity_decoder_unit (
   input  logic clock,
   input  logic reset,
   hed_req_if.sink   req_chan,
   hed_rsp_if.source rsp_chan
);
   import hed_pkg::*;

   // burst handoff between front and back end
   logic      push, pop, queue_full, queue_not_empty;
   burst_type push_burst, pop_burst;

   // match tracking and burst forming
   hed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_burst (push_burst)
   );

   // decouples input acceptance from result playout
   hed_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_burst  (pop_burst)
   );

   // one result item per cycle from the current burst, while the output is ready
   hed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .pop_burst (pop_burst),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
